// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle (consequent may add delay)
`define ERF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ERF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/erf_pkg.sv -----
// ---------------------------------------------------------------------------
// erf_pkg
// Types, codes and constants of the record ring allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package erf_pkg;

  // default geometry
  localparam int NUM_SOURCES_DEF = 16;
  localparam int OFFSET_BITS_DEF = 24;

  // slot layout: length prefix plus payload, rounded to the alignment
  localparam int SLOT_ALIGN   = 8;
  localparam int PREFIX_BYTES = 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEV    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REC    = 3'd4;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [23:0] RING_BYTES_RST = 24'd65536;
  localparam logic [7:0]  MIN_SEV_RST    = 8'd0;
  localparam logic [31:0] SRC_MASK_RST   = 32'hFFFF_FFFF;
  localparam logic [15:0] MIN_REC_RST    = 16'd16;
  localparam logic [15:0] MAX_REC_RST    = 16'd4096;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_FILTERED   = 3'd1,
    ST_DROP_FULL  = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_READ_TAKEN = 3'd4
  } erf_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } erf_state_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] record_bytes;
    logic [7:0]  source_id;
    logic [7:0]  severity;
    logic [23:0] read_offset;
  } erf_in_t;

  typedef struct packed {
    erf_status_t status;
    logic [23:0] write_offset;
    logic [15:0] length_word;
    logic [16:0] slot_bytes;
    logic        notify;
    logic [31:0] source_drops;
    logic [31:0] total_stored;
  } erf_out_t;

  typedef struct packed {
    logic [23:0] ring_bytes;
    logic [7:0]  sev_thresh;
    logic [31:0] src_enable;
    logic [15:0] min_record_bytes;
    logic [15:0] max_record_bytes;
  } erf_cfg_t;

  // update requests from the evaluation logic
  typedef struct packed {
    logic store;
    logic drop;
    logic rd_set;
  } erf_ctl_t;

endpackage

`default_nettype wire

// ----- sv/erf_ram.sv -----
// ---------------------------------------------------------------------------
// erf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module erf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/erf_alloc.sv -----
// ---------------------------------------------------------------------------
// erf_alloc
// Evaluates one word: size check, filter, free space, placement and the
// counter updates.
// ---------------------------------------------------------------------------
`default_nettype none

module erf_alloc #(
  parameter int NUM_SOURCES = erf_pkg::NUM_SOURCES_DEF,
  parameter int OFFSET_BITS = erf_pkg::OFFSET_BITS_DEF
) (
  input  wire erf_pkg::erf_in_t         item,
  input  wire erf_pkg::erf_cfg_t        cfg,
  input  wire logic [OFFSET_BITS-1:0]   w_idx,
  input  wire logic [OFFSET_BITS-1:0]   r_idx,
  input  wire logic [31:0]              drop_cnt,
  input  wire logic [31:0]              stored_cnt,
  output erf_pkg::erf_out_t             res,
  output erf_pkg::erf_ctl_t             ctl,
  output logic      [OFFSET_BITS-1:0]   w_idx_nxt,
  output logic      [OFFSET_BITS-1:0]   r_idx_nxt,
  output logic      [31:0]              drop_nxt,
  output logic      [31:0]              stored_nxt
);

  import erf_pkg::*;

  // common compare width for indexes and ring size
  localparam int FW  = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;
  localparam int FW1 = FW + 1;

  logic             src_ok;
  logic             size_bad;
  logic             filt;
  logic [16:0]      slot;
  logic [FW-1:0]    w_x;
  logic [FW-1:0]    r_x;
  logic [FW-1:0]    ring_x;
  logic [FW-1:0]    diff;
  logic [FW-1:0]    free_b;
  logic [FW1-1:0]   need;
  logic [FW1-1:0]   end_pos;
  logic             full;
  logic             wrap;
  logic [OFFSET_BITS-1:0] place;
  logic [31:0]      place32;
  logic [31:0]      roff32;
  logic [31:0]      drop_inc;

  // classification
  assign src_ok   = item.source_id < 8'(NUM_SOURCES);
  assign size_bad = (item.record_bytes < cfg.min_record_bytes) ||
                    (item.record_bytes > cfg.max_record_bytes);
  assign filt     = !src_ok || (item.severity < cfg.sev_thresh) ||
                    !cfg.src_enable[item.source_id[4:0]];

  // slot size: length + prefix, rounded up to the alignment
  assign slot = (17'(item.record_bytes) + 17'(PREFIX_BYTES + SLOT_ALIGN - 1)) &
                ~17'(SLOT_ALIGN - 1);

  // free space, with one extra prefix of margin
  assign w_x    = FW'(w_idx);
  assign r_x    = FW'(r_idx);
  assign ring_x = FW'(cfg.ring_bytes);
  assign diff   = w_x - r_x;

  always_comb begin
    if (w_x >= r_x) begin
      free_b = (diff >= ring_x) ? '0 : (ring_x - diff);
    end else begin
      free_b = r_x - w_x;
    end
  end

  assign need    = FW1'(slot) + FW1'(PREFIX_BYTES);
  assign full    = FW1'(free_b) < need;

  // placement: wrap to zero when the tail is too short
  assign end_pos = FW1'(w_x) + FW1'(slot);
  assign wrap    = end_pos > FW1'(ring_x);
  assign place   = wrap ? '0 : w_idx;
  assign place32 = 32'(place);

  // read offset masked to the index width
  assign roff32  = 32'(item.read_offset);

  assign drop_inc = (drop_cnt == SAT32) ? drop_cnt : drop_cnt + 32'd1;

  // decision and result word
  always_comb begin
    res        = '0;
    ctl        = '0;
    w_idx_nxt  = w_idx;
    r_idx_nxt  = r_idx;
    drop_nxt   = drop_cnt;
    stored_nxt = stored_cnt;
    priority if (item.mode) begin
      ctl.rd_set = 1'b1;
      r_idx_nxt  = roff32[OFFSET_BITS-1:0];
      res.status = ST_READ_TAKEN;
    end else if (size_bad) begin
      res.status = ST_BAD_SIZE;
    end else if (filt) begin
      res.status = ST_FILTERED;
    end else if (full) begin
      ctl.drop   = 1'b1;
      drop_nxt   = drop_inc;
      res.status = ST_DROP_FULL;
    end else begin
      ctl.store        = 1'b1;
      res.status       = ST_STORED;
      res.notify       = (w_idx == r_idx);
      res.write_offset = place32[23:0];
      res.length_word  = item.record_bytes;
      res.slot_bytes   = slot;
      w_idx_nxt        = place + OFFSET_BITS'(slot);
      stored_nxt       = (stored_cnt == SAT32) ? stored_cnt : stored_cnt + 32'd1;
    end
    if (!item.mode && src_ok) begin
      res.source_drops = drop_nxt;
    end
    res.total_stored = stored_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/event_ring_enqueue_filter.sv -----
// ---------------------------------------------------------------------------
// event_ring_enqueue_filter
// Write-side allocator for a ring of variable-length records, with source
// filtering and per-source saturating drop counters kept in a small RAM.
// ---------------------------------------------------------------------------
//
//  channel   ports                      handshake
//  -------   -------------------------  -----------------------------------
//  input     start, busy, in_word       taken when start && !busy
//  result    out_valid, out_word        one-cycle strobe, cannot be held off
//  config    cfg_we, cfg_addr, cfg_wdata written when cfg_we, no wait
//
//  A word is taken in the idle state, where the source's drop counter is read
//  from the counter RAM (registered read); the exec state then evaluates,
//  writes the counter back and registers the result. The result strobes in the
//  following cycle, during which the next word may already be taken.
//  Reset sets the registers to defaults and clears the counter valid bits
//  directly; there is no clearing pass. The result side never stalls.
//
`default_nettype none

module event_ring_enqueue_filter #(
  parameter int NUM_SOURCES = erf_pkg::NUM_SOURCES_DEF,
  parameter int OFFSET_BITS = erf_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire erf_pkg::erf_in_t              in_word,
  output logic                               out_valid,
  output erf_pkg::erf_out_t                  out_word,
  input  wire logic                          cfg_we,
  input  wire logic [erf_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [erf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import erf_pkg::*;

  localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  erf_state_t             state_r, state_nxt;
  erf_cfg_t               cfg_r;
  erf_in_t                item_r;
  logic [OFFSET_BITS-1:0] w_idx_r, r_idx_r;
  logic [31:0]            stored_r;
  logic [NUM_SOURCES-1:0] valid_r;
  logic                   out_valid_r;
  erf_out_t               out_word_r;

  logic                   accept;
  logic                   exec;
  logic [AW-1:0]          idx_r;
  logic                   src_ok_r;
  logic [31:0]            ram_q;
  logic [31:0]            drop_cnt;
  erf_out_t               res;
  erf_ctl_t               ctl;
  logic [OFFSET_BITS-1:0] w_idx_nxt, r_idx_nxt;
  logic [31:0]            drop_nxt, stored_nxt;

  assign accept   = start && !busy;
  assign exec     = (state_r == S_EXEC);
  assign idx_r    = item_r.source_id[AW-1:0];
  assign src_ok_r = item_r.source_id < 8'(NUM_SOURCES);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        busy      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_bytes       <= RING_BYTES_RST;
      cfg_r.sev_thresh       <= MIN_SEV_RST;
      cfg_r.src_enable       <= SRC_MASK_RST;
      cfg_r.min_record_bytes <= MIN_REC_RST;
      cfg_r.max_record_bytes <= MAX_REC_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RING_BYTES: cfg_r.ring_bytes       <= cfg_wdata[23:0];
        CFG_MIN_SEV:    cfg_r.sev_thresh       <= cfg_wdata[7:0];
        CFG_SRC_MASK:   cfg_r.src_enable       <= cfg_wdata[31:0];
        CFG_MIN_REC:    cfg_r.min_record_bytes <= cfg_wdata[15:0];
        CFG_MAX_REC:    cfg_r.max_record_bytes <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // capture the word; counter read is issued in the same cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_word;
    end
  end

  // per-source drop counters
  erf_ram #(
    .WIDTH (32),
    .DEPTH (NUM_SOURCES),
    .AW    (AW)
  ) u_drop_ram (
    .clk   (clk),
    .we    (exec && ctl.drop),
    .waddr (idx_r),
    .wdata (drop_nxt),
    .raddr (in_word.source_id[AW-1:0]),
    .rdata (ram_q)
  );

  // an entry never written reads as zero
  assign drop_cnt = (src_ok_r && valid_r[idx_r]) ? ram_q : 32'd0;

  erf_alloc #(
    .NUM_SOURCES (NUM_SOURCES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_alloc (
    .item       (item_r),
    .cfg        (cfg_r),
    .w_idx      (w_idx_r),
    .r_idx      (r_idx_r),
    .drop_cnt   (drop_cnt),
    .stored_cnt (stored_r),
    .res        (res),
    .ctl        (ctl),
    .w_idx_nxt  (w_idx_nxt),
    .r_idx_nxt  (r_idx_nxt),
    .drop_nxt   (drop_nxt),
    .stored_nxt (stored_nxt)
  );

  // ring indexes, store count, counter valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_idx_r  <= '0;
      r_idx_r  <= '0;
      stored_r <= '0;
      valid_r  <= '0;
    end else if (exec) begin
      w_idx_r  <= w_idx_nxt;
      r_idx_r  <= r_idx_nxt;
      stored_r <= stored_nxt;
      if (ctl.drop) begin
        valid_r[idx_r] <= 1'b1;
      end
    end
  end

  // result word and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ----- sv/erf_checker.sv -----
// ---------------------------------------------------------------------------
// erf_checker
// Port-level checks on the allocator's timing and result word.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module erf_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire erf_pkg::erf_out_t out_word
);

  import erf_pkg::*;

  // a taken word locks the input for its evaluation cycle
  `ERF_ASSERT_NEXT(a_busy_after_take, start && !busy, busy, "busy not set after take")

  // every taken word strobes a result once its exec state has registered it
  `ERF_ASSERT_IMPL(a_result_latency, start && !busy, ##2 out_valid, "result strobe missing")

  // one word at a time: no back-to-back strobes
  `ERF_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe repeated")

  // placement fields are zero unless the record was stored
  `ERF_ASSERT_IMPL(a_unstored_zero, out_valid && out_word.status != ST_STORED,
    out_word.write_offset == 24'd0 && out_word.slot_bytes == 17'd0 &&
    out_word.length_word == 16'd0 && !out_word.notify, "placement fields set")

  // a read offset update reports no drop count
  `ERF_ASSERT_IMPL(a_rd_no_drops, out_valid && out_word.status == ST_READ_TAKEN,
    out_word.source_drops == 32'd0, "drop count on read offset update")

endmodule

bind event_ring_enqueue_filter erf_checker u_erf_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_event_ring_enqueue_filter.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_event_ring_enqueue_filter
// Self-checking bench for the record ring allocator. A directed table walks
// the size bounds, the source/severity/mask filter, drops on a full ring, the
// wrap to offset zero and the consumer offset writes, with config changes in
// between. Random phases then run producer/consumer traffic plus noise. Every
// result word is compared field by field against the table's expected word,
// or, for rows without one, against an in-bench model of the allocator state.
// ---------------------------------------------------------------------------

module tb_event_ring_enqueue_filter;
  import erf_pkg::*;

  localparam int          ITEMS_PER_PHASE = 75;
  localparam int          NUM_PHASES      = 6;
  localparam int unsigned IDX_MASK        = (1 << OFFSET_BITS_DEF) - 1;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // one step of the directed table: an input word or a register write
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [31:0]           reg_val;
    erf_in_t               word;
    logic                  typed;
    erf_out_t              result;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  erf_in_t               in_word   = '0;
  logic                  out_valid;
  erf_out_t              out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = CFG_RING_BYTES;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // allocator model: registers and ring state
  logic [23:0]  ring_sz     = RING_BYTES_RST;
  logic [7:0]   sev_floor   = MIN_SEV_RST;
  logic [31:0]  src_enables = SRC_MASK_RST;
  logic [15:0]  rec_min     = MIN_REC_RST;
  logic [15:0]  rec_max     = MAX_REC_RST;
  int unsigned  wr_pos      = 0;
  int unsigned  rd_pos      = 0;
  logic [31:0]  drop_cnt [NUM_SOURCES_DEF];
  logic [31:0]  stored_cnt  = '0;

  erf_out_t     placements_q [$];   // results still owed by the block
  int unsigned  commit_ends [$];    // ring offsets where stored records end
  dir_row_t     dir_rows [$];
  int           errors = 0;

  event_ring_enqueue_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    foreach (drop_cnt[i]) drop_cnt[i] = '0;
  end

  // Model of one word: updates ring state and returns the result word.
  function automatic erf_out_t place_record(erf_in_t w);
    erf_out_t    r;
    int unsigned slot;
    int unsigned room;
    int unsigned pos;
    r = '0;
    r.status = ST_STORED;
    if (w.mode) begin
      rd_pos = {8'd0, w.read_offset};
      r.status = ST_READ_TAKEN;
    end else if (w.record_bytes < rec_min || w.record_bytes > rec_max) begin
      r.status = ST_BAD_SIZE;
    end else if (w.source_id >= NUM_SOURCES_DEF || w.severity < sev_floor ||
                 !src_enables[w.source_id[4:0]]) begin
      r.status = ST_FILTERED;
    end else begin
      slot = (w.record_bytes + PREFIX_BYTES + SLOT_ALIGN - 1) / SLOT_ALIGN * SLOT_ALIGN;
      if (wr_pos >= rd_pos)
        room = (wr_pos - rd_pos >= ring_sz) ? 0 : ring_sz - (wr_pos - rd_pos);
      else
        room = rd_pos - wr_pos;
      // an extra prefix of margin is kept on top of the slot
      if (room < slot + PREFIX_BYTES) begin
        if (drop_cnt[w.source_id] != SAT32) drop_cnt[w.source_id]++;
        r.status = ST_DROP_FULL;
      end else begin
        r.notify = (wr_pos == rd_pos);
        // tail too short: slot goes to the ring start, space not rechecked
        pos = (wr_pos + slot > ring_sz) ? 0 : wr_pos;
        r.write_offset = pos[23:0];
        r.length_word  = w.record_bytes;
        r.slot_bytes   = slot[16:0];
        wr_pos = (pos + slot) & IDX_MASK;
        if (stored_cnt != SAT32) stored_cnt++;
        commit_ends.push_back(wr_pos);
      end
    end
    if (!w.mode && w.source_id < NUM_SOURCES_DEF) r.source_drops = drop_cnt[w.source_id];
    r.total_stored = stored_cnt;
    return r;
  endfunction

  function automatic erf_in_t wd(logic mode, logic [15:0] rec, logic [7:0] src,
                                 logic [7:0] sev, logic [23:0] roff);
    erf_in_t w;
    w.mode = mode;
    w.record_bytes = rec;
    w.source_id = src;
    w.severity = sev;
    w.read_offset = roff;
    return w;
  endfunction

  function automatic erf_out_t rs(erf_status_t st, logic [23:0] woff, logic [15:0] len,
                                  logic [16:0] slot, logic notify, logic [31:0] drops,
                                  logic [31:0] total);
    erf_out_t r;
    r.status = st;
    r.write_offset = woff;
    r.length_word = len;
    r.slot_bytes = slot;
    r.notify = notify;
    r.source_drops = drops;
    r.total_stored = total;
    return r;
  endfunction

  function automatic void row_word(erf_in_t w);
    dir_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.word = w;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_checked(erf_in_t w, erf_out_t r);
    dir_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.word = w;
    row.typed = 1'b1;
    row.result = r;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endfunction

  // Random word: mostly producer records that pass the filter, some consumer
  // offset updates, the rest unconstrained noise.
  function automatic erf_in_t make_item();
    erf_in_t     w;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned k;
    int unsigned junk;
    int unsigned src;
    w.mode = 1'b0;
    w.record_bytes = $urandom;
    w.source_id = $urandom;
    w.severity = $urandom;
    w.read_offset = $urandom;
    pick = $urandom_range(99);
    if (pick < 15) begin
      w.mode = 1'b1;
      // consumer catches up to the end of some stored record
      if (pick < 11 && commit_ends.size() != 0) begin
        k = $urandom_range(commit_ends.size() - 1);
        w.read_offset = commit_ends[k][23:0];
        repeat (k + 1) junk = commit_ends.pop_front();
      end
    end else if (pick < 85) begin
      lo = rec_min;
      hi = rec_max;
      if (lo <= hi) begin
        if ($urandom_range(7) != 0 && hi - lo > ring_sz / 8) hi = lo + ring_sz / 8;
        w.record_bytes = $urandom_range(lo, hi);
      end else begin
        w.record_bytes = $urandom_range(hi, lo);
      end
      src = $urandom_range(NUM_SOURCES_DEF - 1);
      repeat (8) if (!src_enables[src]) src = $urandom_range(NUM_SOURCES_DEF - 1);
      w.source_id = src[7:0];
      w.severity = $urandom_range(sev_floor, 255);
    end
    return w;
  endfunction

  function automatic void match_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result checker: the block cannot be held off, so every strobe is taken.
  always @(posedge clk) begin : check_results
    erf_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (placements_q.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual %h",
                 $time, out_word);
        errors++;
      end else begin
        want = placements_q.pop_front();
        match_field("status", want.status, out_word.status);
        match_field("write_offset", want.write_offset, out_word.write_offset);
        match_field("length_word", want.length_word, out_word.length_word);
        match_field("slot_bytes", want.slot_bytes, out_word.slot_bytes);
        match_field("notify", want.notify, out_word.notify);
        match_field("source_drops", want.source_drops, out_word.source_drops);
        match_field("total_stored", want.total_stored, out_word.total_stored);
      end
    end
  end

  // Wait for all owed results, then for the pipeline to empty.
  task automatic settle();
    start <= 1'b0;
    while (placements_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RING_BYTES: ring_sz = val[23:0];
      CFG_MIN_SEV:    sev_floor = val[7:0];
      CFG_SRC_MASK:   src_enables = val;
      CFG_MIN_REC:    rec_min = val[15:0];
      CFG_MAX_REC:    rec_max = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one word, idling each cycle with the given odds ahead of it, and log
  // its result once taken.
  task automatic drive_item(input erf_in_t w, input logic typed, input erf_out_t r,
                            input int idle_pct);
    erf_out_t pred;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pred = place_record(w);
    placements_q.push_back(typed ? r : pred);
  endtask

  initial begin : stimulus
    erf_in_t     w;
    int          idle;
    logic [31:0] ring_v;
    logic [31:0] sev_v;
    logic [31:0] mask_v;
    logic [31:0] mn_v;
    logic [31:0] mx_v;

    // directed table, defaults after reset
    row_checked(wd(0, 16, 0, 0, 0), rs(ST_STORED, 0, 16, 24, 1, 0, 1));
    row_checked(wd(0, 15, 1, 0, 0), rs(ST_BAD_SIZE, 0, 0, 0, 0, 0, 1));
    row_checked(wd(0, 4097, 1, 0, 0), rs(ST_BAD_SIZE, 0, 0, 0, 0, 0, 1));
    row_checked(wd(0, 4096, 15, 8'hFF, 0), rs(ST_STORED, 24, 4096, 4104, 0, 0, 2));
    row_checked(wd(0, 100, 16, 0, 0), rs(ST_FILTERED, 0, 0, 0, 0, 0, 2));
    row_checked(wd(0, 16'hFFFF, 8'hFF, 8'hFF, 24'hFFFFFF),
                rs(ST_BAD_SIZE, 0, 0, 0, 0, 0, 2));
    row_checked(wd(0, 0, 0, 0, 0), rs(ST_BAD_SIZE, 0, 0, 0, 0, 0, 2));
    row_checked(wd(1, 0, 3, 0, 24'hFFFFFF), rs(ST_READ_TAKEN, 0, 0, 0, 0, 0, 2));
    // read offset meets write offset: ring empty again
    row_checked(wd(1, 16'hFFFF, 3, 8'hFF, 24'd4128), rs(ST_READ_TAKEN, 0, 0, 0, 0, 0, 2));
    row_word(wd(0, 20, 2, 7, 0));
    // severity floor and source mask
    row_reg(CFG_MIN_SEV, 32'h80);
    row_reg(CFG_SRC_MASK, 32'h0000_8005);
    row_checked(wd(0, 32, 2, 8'h7F, 0), rs(ST_FILTERED, 0, 0, 0, 0, 0, 3));
    row_checked(wd(0, 32, 1, 8'h80, 0), rs(ST_FILTERED, 0, 0, 0, 0, 0, 3));
    row_word(wd(0, 32, 0, 8'h80, 0));
    // smallest ring: wrap to zero, then drops of records larger than the free space
    row_reg(CFG_RING_BYTES, 32'd1024);
    row_word(wd(0, 16, 15, 8'hFF, 0));
    row_word(wd(1, 0, 0, 0, 0));
    row_word(wd(0, 1000, 0, 8'h80, 0));
    row_word(wd(0, 1000, 0, 8'h80, 0));
    // inverted bounds
    row_reg(CFG_MIN_REC, 32'd100);
    row_reg(CFG_MAX_REC, 32'd50);
    row_word(wd(0, 75, 0, 8'h80, 0));
    // widest bounds, largest ring, all sources masked
    row_reg(CFG_MIN_REC, 32'd1);
    row_reg(CFG_MAX_REC, 32'hFFFF);
    row_reg(CFG_MIN_SEV, 32'h0);
    row_reg(CFG_SRC_MASK, 32'h0);
    row_reg(CFG_RING_BYTES, 32'hFF_FFFF);
    row_word(wd(0, 1, 0, 0, 0));
    row_reg(CFG_SRC_MASK, 32'hFFFF_FFFF);
    row_word(wd(0, 16'hFFFF, 0, 0, 0));
    row_word(wd(0, 1, 3, 0, 0));
    row_word(wd(1, 0, 0, 0, 24'h800000));
    row_word(wd(1, 0, 0, 0, 0));
    // fill level beyond a shrunk ring: no free space at all
    row_reg(CFG_RING_BYTES, 32'd1024);
    row_word(wd(0, 16, 5, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        drive_item(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result, 19);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          ring_v = 32'd1024;
          sev_v = 32'd0;
          mask_v = 32'hFFFF_FFFF;
          mn_v = 32'd1;
          mx_v = 32'hFFFF;
        end
        1: begin
          ring_v = 32'hFF_FFFF;
          sev_v = 32'd255;
          mask_v = 32'h0000_FFFF;
          mn_v = 32'hFFFF;
          mx_v = 32'hFFFF;
        end
        default: begin
          ring_v = $urandom_range(1024, 16384);
          sev_v = $urandom_range(0, 200);
          mask_v = $urandom | $urandom;
          mn_v = $urandom_range(1, 64);
          mx_v = $urandom_range(mn_v, 2048);
        end
      endcase
      write_reg(CFG_RING_BYTES, ring_v);
      write_reg(CFG_MIN_SEV, sev_v);
      write_reg(CFG_SRC_MASK, mask_v);
      write_reg(CFG_MIN_REC, mn_v);
      write_reg(CFG_MAX_REC, mx_v);
      idle = (ph < 2) ? 19 : (ph < 4) ? 53 : 0;
      repeat (ITEMS_PER_PHASE) begin
        w = make_item();
        drive_item(w, 1'b0, '0, idle);
      end
    end

    settle();
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
